// File: rtl/core/led_status_breath_flash_controller_defines.svh
// Assertion macros shared by the RTL of the LED status controller.
// Each macro wraps one concurrent property clocked on clk and disabled in reset.
`ifndef LED_STATUS_BREATH_FLASH_CONTROLLER_DEFINES_SVH
`define LED_STATUS_BREATH_FLASH_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define LSBF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsbf: same-cycle check failed");
`define LSBF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsbf: next-cycle check failed");
`else
`define LSBF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define LSBF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/lsbf_pkg.sv
package lsbf_pkg;

  localparam int IDX_W     = 4;
  localparam int CH_W      = 8;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 2;

  typedef logic [2:0] cmd_code_t;

  localparam cmd_code_t CMD_SET_LED    = 3'd0;
  localparam cmd_code_t CMD_SET_STATUS = 3'd1;
  localparam cmd_code_t CMD_PALETTE    = 3'd2;
  localparam cmd_code_t CMD_FLASH      = 3'd3;
  localparam cmd_code_t CMD_BRIGHTNESS = 3'd4;
  localparam cmd_code_t CMD_UPDATE     = 3'd5;
  localparam cmd_code_t CMD_ALL_OFF    = 3'd6;

  localparam logic [REG_IDX_W-1:0] REG_BREATH_INTERVAL = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLASH_DURATION  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLASH_BOOST     = 2'd2;

  localparam logic [1:0] ST_DISCONNECTED = 2'd0;
  localparam logic [1:0] ST_CONNECTING   = 2'd1;
  localparam logic [1:0] ST_CONNECTED    = 2'd2;
  localparam logic [1:0] ST_RECONNECTING = 2'd3;

  localparam logic [CFG_W-1:0] BREATH_INTERVAL_RST = 16'd20;
  localparam logic [CFG_W-1:0] FLASH_DURATION_RST  = 16'd150;
  localparam logic [CH_W-1:0]  FLASH_BOOST_RST     = 8'd64;
  localparam logic [CH_W-1:0]  FULL_LEVEL          = 8'd255;

  // x/100 == (x*5243) >> 19 for every x the breathing product can reach
  localparam logic [12:0] RECIP_100       = 13'd5243;
  localparam int          RECIP_100_SHIFT = 19;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    cmd_code_t         command;
    logic [IDX_W-1:0]  led_index;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [1:0]        status_code;
    logic [CH_W-1:0]   level;
    logic [TIME_W-1:0] time_ms;
  } cmd_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             last;
  } led_word_t;

  // Breathing intensity in percent, indexed by the breathing step
  localparam logic [6:0] BREATH_TABLE [128] = '{
    7'd65, 7'd66, 7'd68, 7'd70, 7'd71, 7'd73, 7'd75, 7'd76, 7'd78, 7'd80,
    7'd81, 7'd83, 7'd84, 7'd85, 7'd87, 7'd88, 7'd89, 7'd91, 7'd92, 7'd93,
    7'd94, 7'd95, 7'd95, 7'd96, 7'd97, 7'd98, 7'd98, 7'd98, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd98, 7'd98, 7'd97,
    7'd97, 7'd96, 7'd95, 7'd94, 7'd93, 7'd92, 7'd91, 7'd90, 7'd89, 7'd88,
    7'd86, 7'd85, 7'd84, 7'd82, 7'd81, 7'd79, 7'd78, 7'd76, 7'd74, 7'd73,
    7'd71, 7'd69, 7'd68, 7'd66, 7'd64, 7'd62, 7'd61, 7'd59, 7'd57, 7'd56,
    7'd54, 7'd52, 7'd51, 7'd49, 7'd48, 7'd46, 7'd45, 7'd43, 7'd42, 7'd41,
    7'd39, 7'd38, 7'd37, 7'd36, 7'd35, 7'd34, 7'd33, 7'd33, 7'd32, 7'd31,
    7'd31, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30,
    7'd30, 7'd31, 7'd31, 7'd32, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37,
    7'd38, 7'd39, 7'd40, 7'd42, 7'd43, 7'd44, 7'd46, 7'd47, 7'd49, 7'd50,
    7'd52, 7'd53, 7'd55, 7'd57, 7'd58, 7'd60, 7'd62, 7'd64
  };

  function automatic rgb_t status_color_of(input logic [1:0] code);
    rgb_t c;
    case (code)
      ST_CONNECTING:   c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      ST_CONNECTED:    c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      ST_RECONNECTING: c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      ST_DISCONNECTED: c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      default:         c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
    endcase
    return c;
  endfunction

  // Exact x/255 for any product of two 8-bit values
  function automatic logic [CH_W-1:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return s[15:8];
  endfunction

  function automatic logic [CH_W-1:0] div100(input logic [15:0] p);
    logic [28:0] m;
    m = 29'(p) * 29'(RECIP_100);
    return m[RECIP_100_SHIFT+CH_W-1:RECIP_100_SHIFT];
  endfunction

  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] c,
                                              input logic [CH_W-1:0] boost);
    logic [CH_W:0] s;
    s = {1'b0, c} + {1'b0, boost};
    return s[CH_W] ? FULL_LEVEL : s[CH_W-1:0];
  endfunction

endpackage

// File: rtl/core/lsbf_stream_if.sv
interface lsbf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/led_status_breath_flash_controller.sv
// A command word is taken in S_IDLE; each LED write then goes through S_NEXT (select),
//   an S_MUL and an S_DIV step per color channel for each pass of the shared 8x8
//   multiply/divide unit, and S_EMIT (emit). Brightness scaling is one pass when
//   brightness is not 255; a breathing write adds one. A new command is taken only
//   in S_IDLE; the single multiplier, shared by all channels, sets the rate.
// Reset (rst, synchronous): config defaults, palette black, status red, brightness 255.
`include "led_status_breath_flash_controller_defines.svh"

module led_status_breath_flash_controller #(
  parameter int PALETTE_LEDS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lsbf_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [lsbf_pkg::CFG_W-1:0]        cfg_data,
  lsbf_stream_if.sink                       cmd,
  lsbf_stream_if.source                     led
);

  localparam int IW = (PALETTE_LEDS > 1) ? $clog2(PALETTE_LEDS) : 1;
  localparam logic [lsbf_pkg::IDX_W-1:0] LED_P = lsbf_pkg::IDX_W'(PALETTE_LEDS);

  typedef enum logic [2:0] {S_IDLE, S_NEXT, S_MUL, S_DIV, S_EMIT} state_t;

  state_t state;

  logic [lsbf_pkg::CFG_W-1:0]  breath_interval;
  logic [lsbf_pkg::CFG_W-1:0]  flash_duration;
  logic [lsbf_pkg::CH_W-1:0]   flash_boost;

  lsbf_pkg::rgb_t              palette [PALETTE_LEDS];
  lsbf_pkg::rgb_t              status_color;
  logic [lsbf_pkg::CH_W-1:0]   brightness;
  logic                        breathing_on;
  logic [6:0]                  breath_step;
  logic [lsbf_pkg::TIME_W-1:0] last_breath_time;
  logic                        flash_on;
  logic [IW-1:0]               flash_led;
  logic [lsbf_pkg::TIME_W-1:0] flash_start_time;

  logic                        pend_breath;
  logic                        pend_flash;
  logic                        pend_sweep;
  logic                        pend_one;
  logic                        boost_now;
  logic                        sweep_zero;
  logic [lsbf_pkg::IDX_W-1:0]  sweep_cnt;
  logic [lsbf_pkg::IDX_W-1:0]  one_idx;
  logic [6:0]                  breath_k;

  lsbf_pkg::rgb_t              cur;
  logic [lsbf_pkg::IDX_W-1:0]  cur_idx;
  logic                        cur_last;
  logic                        cur_breath;
  logic                        cur_scale;
  logic [1:0]                  ch;
  logic [15:0]                 prod;

  logic                        out_valid;
  lsbf_pkg::led_word_t         out_word;

  lsbf_pkg::cmd_word_t         cw;
  logic                        idx_pal;
  logic [IW-1:0]               cw_addr;
  logic [lsbf_pkg::TIME_W-1:0] breath_age;
  logic [lsbf_pkg::TIME_W-1:0] flash_age;
  logic                        breath_due;
  logic                        flash_due;
  logic [6:0]                  step_next;
  logic [IW-1:0]               rd_addr;
  lsbf_pkg::rgb_t              pal_rd;
  lsbf_pkg::rgb_t              pal_boost;
  logic [lsbf_pkg::CH_W-1:0]   ch_val;
  logic [lsbf_pkg::CH_W-1:0]   mul_op;
  logic [lsbf_pkg::CH_W-1:0]   quot;
  logic                        do_scale;

  assign cw         = cmd.data;
  assign cmd.ready  = (state == S_IDLE);
  assign led.valid  = out_valid;
  assign led.data   = out_word;

  assign idx_pal    = (cw.led_index < LED_P);
  assign cw_addr    = cw.led_index[IW-1:0];
  assign breath_age = cw.time_ms - last_breath_time;
  assign flash_age  = cw.time_ms - flash_start_time;
  assign breath_due = (breath_age >= {16'd0, breath_interval});
  assign flash_due  = (flash_age >= {16'd0, flash_duration});
  assign step_next  = breath_step + 7'd1;
  assign do_scale   = (brightness != lsbf_pkg::FULL_LEVEL);

  always_comb begin
    if (pend_flash) begin
      rd_addr = flash_led;
    end else if (pend_sweep) begin
      rd_addr = sweep_cnt[IW-1:0];
    end else begin
      rd_addr = one_idx[IW-1:0];
    end
  end

  assign pal_rd      = palette[rd_addr];
  assign pal_boost.r = lsbf_pkg::sat_add(pal_rd.r, flash_boost);
  assign pal_boost.g = lsbf_pkg::sat_add(pal_rd.g, flash_boost);
  assign pal_boost.b = lsbf_pkg::sat_add(pal_rd.b, flash_boost);

  // Shared unit: one channel multiply, then a constant divide on the registered product
  always_comb begin
    case (ch)
      2'd0:    ch_val = cur.r;
      2'd1:    ch_val = cur.g;
      default: ch_val = cur.b;
    endcase
  end

  assign mul_op = cur_breath ? {1'b0, breath_k} : brightness;
  assign quot   = cur_breath ? lsbf_pkg::div100(prod) : lsbf_pkg::div255(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      breath_interval  <= lsbf_pkg::BREATH_INTERVAL_RST;
      flash_duration   <= lsbf_pkg::FLASH_DURATION_RST;
      flash_boost      <= lsbf_pkg::FLASH_BOOST_RST;
      for (int i = 0; i < PALETTE_LEDS; i++) begin
        palette[i] <= '0;
      end
      status_color     <= lsbf_pkg::status_color_of(lsbf_pkg::ST_DISCONNECTED);
      brightness       <= lsbf_pkg::FULL_LEVEL;
      breathing_on     <= 1'b0;
      breath_step      <= '0;
      last_breath_time <= '0;
      flash_on         <= 1'b0;
      flash_led        <= '0;
      flash_start_time <= '0;
      pend_breath      <= 1'b0;
      pend_flash       <= 1'b0;
      pend_sweep       <= 1'b0;
      pend_one         <= 1'b0;
      cur_breath       <= 1'b0;
      ch               <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lsbf_pkg::REG_BREATH_INTERVAL: breath_interval <= cfg_data;
          lsbf_pkg::REG_FLASH_DURATION:  flash_duration  <= cfg_data;
          lsbf_pkg::REG_FLASH_BOOST:     flash_boost     <= cfg_data[lsbf_pkg::CH_W-1:0];
          default: ;
        endcase
      end

      // drop a taken word; S_EMIT reloads the register on its own
      if (out_valid && led.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            state <= S_NEXT;
            case (cw.command)
              lsbf_pkg::CMD_SET_LED: begin
                if (idx_pal) begin
                  palette[cw_addr] <= '{r: cw.red, g: cw.green, b: cw.blue};
                end else if (cw.led_index == LED_P) begin
                  status_color <= '{r: cw.red, g: cw.green, b: cw.blue};
                end
                pend_one <= (cw.led_index <= LED_P);
                one_idx  <= cw.led_index;
              end
              lsbf_pkg::CMD_SET_STATUS: begin
                status_color <= lsbf_pkg::status_color_of(cw.status_code);
                // connecting and reconnecting are the odd codes
                breathing_on <= cw.status_code[0];
                pend_one     <= !cw.status_code[0];
                one_idx      <= LED_P;
              end
              lsbf_pkg::CMD_PALETTE: begin
                if (idx_pal) begin
                  palette[cw_addr] <= '{r: cw.red, g: cw.green, b: cw.blue};
                  pend_one <= !(flash_on && (flash_led == cw_addr));
                end
                one_idx <= cw.led_index;
              end
              lsbf_pkg::CMD_FLASH: begin
                if (idx_pal) begin
                  flash_on         <= 1'b1;
                  flash_led        <= cw_addr;
                  flash_start_time <= cw.time_ms;
                end
              end
              lsbf_pkg::CMD_BRIGHTNESS: begin
                brightness <= cw.level;
                pend_sweep <= 1'b1;
                sweep_zero <= 1'b0;
                sweep_cnt  <= '0;
              end
              lsbf_pkg::CMD_UPDATE: begin
                if (breathing_on && breath_due) begin
                  last_breath_time <= cw.time_ms;
                  breath_step      <= step_next;
                  breath_k         <= lsbf_pkg::BREATH_TABLE[step_next];
                  pend_breath      <= 1'b1;
                end
                if (flash_on) begin
                  pend_flash <= 1'b1;
                  boost_now  <= !flash_due;
                  if (flash_due) begin
                    flash_on <= 1'b0;
                  end
                end
              end
              lsbf_pkg::CMD_ALL_OFF: begin
                pend_sweep <= 1'b1;
                sweep_zero <= 1'b1;
                sweep_cnt  <= '0;
              end
              default: ;
            endcase
          end
        end

        S_NEXT: begin
          ch <= '0;
          if (pend_breath) begin
            pend_breath <= 1'b0;
            cur_idx     <= LED_P;
            cur         <= status_color;
            cur_breath  <= 1'b1;
            cur_scale   <= do_scale;
            cur_last    <= !pend_flash;
            state       <= S_MUL;
          end else if (pend_flash) begin
            pend_flash <= 1'b0;
            cur_idx    <= lsbf_pkg::IDX_W'(flash_led);
            cur        <= boost_now ? pal_boost : pal_rd;
            cur_breath <= 1'b0;
            cur_scale  <= do_scale;
            cur_last   <= 1'b1;
            state      <= do_scale ? S_MUL : S_EMIT;
          end else if (pend_sweep) begin
            cur_idx    <= sweep_cnt;
            cur_breath <= 1'b0;
            cur_scale  <= do_scale && !sweep_zero;
            cur_last   <= (sweep_cnt == LED_P);
            if (sweep_zero) begin
              cur <= '0;
            end else if (sweep_cnt == LED_P) begin
              cur <= status_color;
            end else begin
              cur <= pal_rd;
            end
            if (sweep_cnt == LED_P) begin
              pend_sweep <= 1'b0;
            end
            sweep_cnt <= sweep_cnt + lsbf_pkg::IDX_W'(1);
            state     <= (do_scale && !sweep_zero) ? S_MUL : S_EMIT;
          end else if (pend_one) begin
            pend_one   <= 1'b0;
            cur_idx    <= one_idx;
            cur        <= (one_idx == LED_P) ? status_color : pal_rd;
            cur_breath <= 1'b0;
            cur_scale  <= do_scale;
            cur_last   <= 1'b1;
            state      <= do_scale ? S_MUL : S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end

        S_MUL: begin
          prod  <= 16'(ch_val) * 16'(mul_op);
          state <= S_DIV;
        end

        S_DIV: begin
          case (ch)
            2'd0:    cur.r <= quot;
            2'd1:    cur.g <= quot;
            default: cur.b <= quot;
          endcase
          if (ch == 2'd2) begin
            ch <= '0;
            // pass done; after a breathing pass, run the brightness pass if needed
            if (cur_breath && cur_scale) begin
              cur_breath <= 1'b0;
              state      <= S_MUL;
            end else begin
              cur_breath <= 1'b0;
              state      <= S_EMIT;
            end
          end else begin
            ch    <= ch + 2'd1;
            state <= S_MUL;
          end
        end

        S_EMIT: begin
          // load the output register once it is free or being drained
          if (!out_valid || led.ready) begin
            out_valid          <= 1'b1;
            out_word.out_index <= cur_idx;
            out_word.out_red   <= cur.r;
            out_word.out_green <= cur.g;
            out_word.out_blue  <= cur.b;
            out_word.last      <= cur_last;
            state              <= cur_last ? S_IDLE : S_NEXT;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `LSBF_ASSERT_IMPL(a_idle_drained, clk, rst, state == S_IDLE, !(pend_breath || pend_flash || pend_sweep || pend_one))
  `LSBF_ASSERT_IMPL(a_breath_on_status, clk, rst, (state == S_MUL) && cur_breath, cur_idx == LED_P)
  `LSBF_ASSERT_IMPL(a_out_index_range, clk, rst, out_valid, out_word.out_index <= LED_P)
  `LSBF_ASSERT_NEXT(a_busy_after_take, clk, rst, cmd.valid && cmd.ready, !cmd.ready)
  `LSBF_ASSERT_IMPL(a_channel_range, clk, rst, (state == S_MUL) || (state == S_DIV), ch != 2'd3)

endmodule
